// ===== src/gait_foot_trajectory_generator_core_assert.svh =====
// Assertion macros for the foot trajectory generator.
// Used by gait_foot_trajectory_generator_core; needs clk and arst_n in scope.
`ifndef GAIT_FOOT_TRAJECTORY_GENERATOR_CORE_ASSERT_SVH
`define GAIT_FOOT_TRAJECTORY_GENERATOR_CORE_ASSERT_SVH

// condition that must hold at every edge out of reset
`define GFTG_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// same-cycle implication
`define GFTG_ASSERT_IMPLY(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define GFTG_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== src/gftg_pkg.sv =====
// Shared types, codes and constant tables for the foot trajectory generator.
// No dependencies.
package gftg_pkg;

	localparam int NUM_LEGS                 = 6;
	localparam int POINT_INDEX_BITS_DEFAULT = 10;

	// quotient width of the dividers; results never exceed a 15-bit register
	localparam int QuotBits  = 15;
	localparam int RegBits   = 15;
	localparam int CountBits = 10;

	localparam logic [14:0] STEP_LENGTH_RESET   = 15'd1536;
	localparam logic [14:0] LIFT_HEIGHT_RESET   = 15'd1024;
	localparam logic [9:0]  SWING_POINTS_RESET  = 10'd120;
	localparam logic [9:0]  STANCE_POINTS_RESET = 10'd60;

	localparam logic signed [15:0] BASE_Z = -16'sd6144;

	typedef enum logic [1:0] {
		REG_STEP_LENGTH   = 2'd0,
		REG_LIFT_HEIGHT   = 2'd1,
		REG_SWING_POINTS  = 2'd2,
		REG_STANCE_POINTS = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_START_SWING  = 2'd0,
		KIND_START_STANCE = 2'd1,
		KIND_TICK         = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		DIR_FWD        = 3'd0,
		DIR_BACK       = 3'd1,
		DIR_LEFT       = 3'd2,
		DIR_RIGHT      = 3'd3,
		DIR_TURN_LEFT  = 3'd4,
		DIR_TURN_RIGHT = 3'd5
	} dir_t;

	// unit vector component: -1, 0 or +1
	typedef logic signed [1:0] unit_t;

	typedef struct packed {
		unit_t dx;
		unit_t dy;
	} dvec_t;

	function automatic logic signed [15:0] base_x(input logic [2:0] leg);
		logic signed [15:0] v;
		case (leg)
			3'd1: v = 16'sd4608;
			3'd2: v = -16'sd4608;
			3'd3: v = 16'sd5632;
			3'd4: v = -16'sd5632;
			3'd5: v = 16'sd4608;
			3'd6: v = -16'sd4608;
			default: v = 16'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] base_y(input logic [2:0] leg);
		logic signed [15:0] v;
		case (leg)
			3'd1, 3'd2: v = -16'sd3840;
			3'd5, 3'd6: v = 16'sd3840;
			default: v = 16'sd0;
		endcase
		return v;
	endfunction

	function automatic dvec_t dir_vec(input logic [2:0] dir, input logic [2:0] leg);
		dvec_t v;
		logic  front;
		logic  rear;
		front = (leg == 3'd1) || (leg == 3'd2);
		rear  = (leg == 3'd5) || (leg == 3'd6);
		v.dx  = 2'sd0;
		v.dy  = 2'sd0;
		case (dir)
			DIR_FWD:        v.dy = -2'sd1;
			DIR_BACK:       v.dy = 2'sd1;
			DIR_LEFT:       v.dx = 2'sd1;
			DIR_RIGHT:      v.dx = -2'sd1;
			DIR_TURN_LEFT:  v.dx = front ? 2'sd1 : (rear ? -2'sd1 : 2'sd0);
			DIR_TURN_RIGHT: v.dx = front ? -2'sd1 : (rear ? 2'sd1 : 2'sd0);
			default: ;
		endcase
		return v;
	endfunction

	// base + d*mag, saturated to 16 bits
	function automatic logic signed [15:0] place(input logic signed [15:0] base,
			input unit_t d, input logic [14:0] mag);
		logic signed [17:0] s;
		logic signed [17:0] m;
		m = $signed({3'b000, mag});
		case (d)
			2'sd1:   s = 18'(base) + m;
			-2'sd1:  s = 18'(base) - m;
			default: s = 18'(base);
		endcase
		if (s > 18'sd32767)
			return 16'sh7fff;
		else if (s < -18'sd32768)
			return 16'sh8000;
		else
			return s[15:0];
	endfunction

endpackage

// ===== src/gait_foot_trajectory_generator_core.sv =====
// Foot trajectory generator for one hexapod leg: a start word latches leg, direction and
// swing/stance phase; each tick word then yields one foot point. All arithmetic runs through
// one shared shift-add/subtract unit under a step sequencer (products by shift-and-add, the
// two roundings by restoring division), so a tick holds in_stall high while the unit works
// and while the finished point waits for the output register to free up; how long is set by
// the bit lengths of the multipliers (up to P+2 bits for the point terms, 15 for the registers,
// P being POINT_INDEX_BITS) and the 15 quotient bits of each division. A finished point waits
// in the output register while the next word is taken. Uses gftg_pkg and the assertion macro
// header.
`include "gait_foot_trajectory_generator_core_assert.svh"

module gait_foot_trajectory_generator_core
	import gftg_pkg::*;
#(
	parameter int POINT_INDEX_BITS = POINT_INDEX_BITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [RegBits-1:0] cfg_data,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [2:0]         leg,
	input  logic [2:0]         direction,

	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic signed [15:0] pos_z,
	output logic [9:0]         point_number,
	output logic               last
);

	localparam int P   = POINT_INDEX_BITS;
	localparam int WA  = 3 * P + 16;                       // accumulator / operand width
	localparam int MW  = (P + 2 > RegBits) ? P + 2 : RegBits;
	localparam int CW  = (P > CountBits) ? P : CountBits;
	localparam int QCW = $clog2(QuotBits + 1);
	localparam logic [CW-1:0] N_CAP = CW'((1 << P) - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_N2, ST_DEN, ST_I2, ST_NUM, ST_FRAC, ST_MAG_MUL, ST_MAG_DIV,
		ST_ARC_A, ST_ARC_MUL, ST_ARC_DIV, ST_OUT
	} step_t;

	typedef enum logic [1:0] {
		U_MUL, U_DIV, U_SUB
	} unit_mode_t;

	step_t               step_q;
	logic                load_q;
	logic [WA-1:0]       acc_q;
	logic [WA-1:0]       op_q;
	logic [MW-1:0]       mpl_q;
	logic [QCW-1:0]      qcnt_q;
	logic [QuotBits-1:0] quo_q;
	logic [2*P-1:0]      n2_q;
	logic [3*P-1:0]      den_q;
	logic [3*P-1:0]      num_q;
	logic [QuotBits-1:0] mag_q;

	logic                active_q;
	logic                swing_q;
	logic [2:0]          leg_q;
	logic [2:0]          dir_q;
	logic [P-1:0]        pt_q;
	logic [P-1:0]        n_q;

	logic [RegBits-1:0]   step_len_q;
	logic [RegBits-1:0]   lift_q;
	logic [CountBits-1:0] swing_pts_q;
	logic [CountBits-1:0] stance_pts_q;

	logic               out_valid_q;
	logic signed [15:0] pos_x_q;
	logic signed [15:0] pos_y_q;
	logic signed [15:0] pos_z_q;
	logic [9:0]         point_number_q;
	logic               last_q;

	// shared unit
	unit_mode_t  mode;
	logic        alu_sub;
	logic [WA:0] alu_b;
	logic [WA:0] alu_res;
	logic        borrow;

	logic           in_acc;
	logic           start_ok;
	logic [CW-1:0]  n_sel;
	logic [CW-1:0]  n_clamp;
	logic [P+1:0]   t_val;
	logic [P-1:0]   n_minus_i;
	logic [CW-1:0]  pt_ext;
	logic           is_last;
	logic           out_free;
	dvec_t          dv;
	unit_t          sx;
	unit_t          sy;
	logic [QuotBits-1:0] arc;

	always_comb begin
		case (step_q)
			ST_MAG_DIV, ST_ARC_DIV: mode = U_DIV;
			ST_FRAC:                mode = U_SUB;
			default:                mode = U_MUL;
		endcase
		alu_sub = (mode != U_MUL);
		alu_b   = alu_sub ? ~{1'b0, op_q} : {1'b0, op_q};
		alu_res = {1'b0, acc_q} + alu_b + (WA + 1)'(alu_sub);
		borrow  = alu_res[WA];
	end

	always_comb begin
		in_acc    = in_valid && !in_stall;
		start_ok  = (leg >= 3'd1) && (leg <= 3'(NUM_LEGS));
		n_sel     = (kind == KIND_START_SWING) ? CW'(swing_pts_q) : CW'(stance_pts_q);
		if (n_sel == '0)
			n_clamp = CW'(1);
		else if (n_sel > N_CAP)
			n_clamp = N_CAP;
		else
			n_clamp = n_sel;
		// 3n - 2i, never below n
		t_val     = {2'b00, n_q} + {1'b0, n_q, 1'b0} - {1'b0, pt_q, 1'b0};
		n_minus_i = n_q - pt_q;
		pt_ext    = CW'(pt_q);
		is_last   = (pt_q == n_q);
		out_free  = !out_valid_q || !out_stall;
		dv        = dir_vec(dir_q, leg_q);
		sx        = swing_q ? dv.dx : -dv.dx;
		sy        = swing_q ? dv.dy : -dv.dy;
		arc       = swing_q ? quo_q : '0;
	end

	assign in_stall = (step_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_len_q   <= STEP_LENGTH_RESET;
			lift_q       <= LIFT_HEIGHT_RESET;
			swing_pts_q  <= SWING_POINTS_RESET;
			stance_pts_q <= STANCE_POINTS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_LENGTH:   step_len_q   <= cfg_data;
				REG_LIFT_HEIGHT:   lift_q       <= cfg_data;
				REG_SWING_POINTS:  swing_pts_q  <= cfg_data[CountBits-1:0];
				REG_STANCE_POINTS: stance_pts_q <= cfg_data[CountBits-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= ST_IDLE;
			load_q         <= 1'b0;
			acc_q          <= '0;
			op_q           <= '0;
			mpl_q          <= '0;
			qcnt_q         <= '0;
			quo_q          <= '0;
			n2_q           <= '0;
			den_q          <= '0;
			num_q          <= '0;
			mag_q          <= '0;
			active_q       <= 1'b0;
			swing_q        <= 1'b0;
			leg_q          <= 3'd1;
			dir_q          <= 3'd0;
			pt_q           <= '0;
			n_q            <= P'(1);
			out_valid_q    <= 1'b0;
			pos_x_q        <= '0;
			pos_y_q        <= '0;
			pos_z_q        <= '0;
			point_number_q <= '0;
			last_q         <= 1'b0;
		end else begin
			// the output step reloads the word itself
			if (out_valid_q && !out_stall && step_q != ST_OUT)
				out_valid_q <= 1'b0;

			case (step_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (kind)
							KIND_START_SWING, KIND_START_STANCE: begin
								if (start_ok) begin
									active_q <= 1'b1;
									swing_q  <= (kind == KIND_START_SWING);
									leg_q    <= leg;
									dir_q    <= direction;
									pt_q     <= '0;
									n_q      <= n_clamp[P-1:0];
								end
							end
							KIND_TICK: begin
								if (active_q) begin
									step_q <= ST_N2;
									load_q <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end

				ST_OUT: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						pos_x_q        <= place(base_x(leg_q), sx, mag_q);
						pos_y_q        <= place(base_y(leg_q), sy, mag_q);
						pos_z_q        <= BASE_Z + $signed({1'b0, arc});
						point_number_q <= pt_ext[9:0];
						last_q         <= is_last;
						if (is_last)
							active_q <= 1'b0;
						else
							pt_q <= pt_q + P'(1);
						step_q <= ST_IDLE;
					end
				end

				default: begin
					if (load_q) begin
						// operand load for the step just entered
						load_q <= 1'b0;
						case (step_q)
							ST_N2: begin
								acc_q <= '0;
								op_q  <= WA'(n_q);
								mpl_q <= MW'(n_q);
							end
							ST_DEN: begin
								acc_q <= '0;
								op_q  <= WA'(n2_q);
								mpl_q <= MW'(n_q);
							end
							ST_I2: begin
								acc_q <= '0;
								op_q  <= WA'(pt_q);
								mpl_q <= MW'(pt_q);
							end
							ST_NUM: begin
								acc_q <= '0;
								op_q  <= WA'(num_q);
								mpl_q <= MW'(t_val);
							end
							ST_FRAC: begin
								acc_q  <= WA'(den_q);
								op_q   <= WA'(num_q);
								qcnt_q <= QCW'(1);
							end
							ST_MAG_MUL: begin
								// rounding half: start from den/2
								acc_q <= WA'(den_q >> 1);
								op_q  <= WA'(num_q);
								mpl_q <= MW'(step_len_q);
							end
							ST_ARC_A: begin
								acc_q <= '0;
								op_q  <= WA'(pt_q);
								mpl_q <= MW'(n_minus_i);
							end
							ST_ARC_MUL: begin
								acc_q <= WA'(n2_q >> 1);
								op_q  <= WA'(num_q) << 2;
								mpl_q <= MW'(lift_q);
							end
							ST_MAG_DIV: begin
								// dividend stays in acc_q
								op_q   <= WA'(den_q) << (QuotBits - 1);
								qcnt_q <= QCW'(QuotBits);
								quo_q  <= '0;
							end
							ST_ARC_DIV: begin
								op_q   <= WA'(n2_q) << (QuotBits - 1);
								qcnt_q <= QCW'(QuotBits);
								quo_q  <= '0;
							end
							default: ;
						endcase
					end else if ((mode == U_MUL && mpl_q == '0)
							|| (mode != U_MUL && qcnt_q == '0)) begin
						// unit done: keep the result, move to next step
						load_q <= 1'b1;
						case (step_q)
							ST_N2: begin
								n2_q   <= acc_q[2*P-1:0];
								step_q <= ST_DEN;
							end
							ST_DEN: begin
								den_q  <= acc_q[3*P-1:0];
								step_q <= ST_I2;
							end
							ST_I2: begin
								num_q  <= acc_q[3*P-1:0];
								step_q <= ST_NUM;
							end
							ST_NUM: begin
								num_q  <= acc_q[3*P-1:0];
								step_q <= ST_FRAC;
							end
							ST_FRAC: begin
								// stance runs on den - num
								if (!swing_q)
									num_q <= acc_q[3*P-1:0];
								step_q <= ST_MAG_MUL;
							end
							ST_MAG_MUL: step_q <= ST_MAG_DIV;
							ST_MAG_DIV: begin
								mag_q  <= quo_q;
								step_q <= swing_q ? ST_ARC_A : ST_OUT;
							end
							ST_ARC_A: begin
								num_q  <= acc_q[3*P-1:0];
								step_q <= ST_ARC_MUL;
							end
							ST_ARC_MUL: step_q <= ST_ARC_DIV;
							ST_ARC_DIV: step_q <= ST_OUT;
							default:    step_q <= ST_IDLE;
						endcase
					end else begin
						case (mode)
							U_MUL: begin
								if (mpl_q[0])
									acc_q <= alu_res[WA-1:0];
								op_q  <= op_q << 1;
								mpl_q <= mpl_q >> 1;
							end
							U_DIV: begin
								if (!borrow)
									acc_q <= alu_res[WA-1:0];
								quo_q  <= {quo_q[QuotBits-2:0], !borrow};
								op_q   <= op_q >> 1;
								qcnt_q <= qcnt_q - QCW'(1);
							end
							U_SUB: begin
								acc_q  <= alu_res[WA-1:0];
								qcnt_q <= qcnt_q - QCW'(1);
							end
							default: ;
						endcase
					end
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign pos_z        = pos_z_q;
	assign point_number = point_number_q;
	assign last         = last_q;

	`GFTG_ASSERT_IMPLY(a_pt_in_range, active_q, pt_q <= n_q, "point counter past phase length")
	`GFTG_ASSERT_ALWAYS(a_leg_valid, (leg_q >= 3'd1) && (leg_q <= 3'(NUM_LEGS)),
		"latched leg out of range")
	`GFTG_ASSERT_IMPLY(a_word_from_out, $rose(out_valid_q), $past(step_q) == ST_OUT,
		"result word not produced by output step")
	`GFTG_ASSERT_NEXT(a_last_idles, step_q == ST_OUT && out_free && is_last, !active_q,
		"still active after final point")

endmodule

// ===== dv/gftg_point_checker.sv =====
// Checker for the foot trajectory generator: follows config writes and accepted words,
// predicts every foot point and compares it with the point the block hands out.
// Depends on gftg_pkg for the kind, direction and register codes.
`timescale 1ns / 100ps

module gftg_point_checker
	import gftg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [RegBits-1:0] cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [2:0]         leg,
	input  logic [2:0]         direction,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic [9:0]         point_number,
	input  logic               last,
	output int                 fail_count,
	output int                 points_owed
);

	localparam longint HOME_Z = -6144;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [9:0]         index;
		logic               fin;
	} foot_point_t;

	// live registers
	logic [14:0] stride;
	logic [14:0] lift;
	logic [9:0]  swing_n;
	logic [9:0]  stance_n;

	// phase latched at start
	logic        walking;
	logic        swinging;
	logic [2:0]  leg_q;
	logic [2:0]  dir_q;
	logic [9:0]  idx_q;
	logic [9:0]  n_q;

	foot_point_t points_due[$];

	function automatic longint home_x(input logic [2:0] l);
		case (l)
			3'd1, 3'd5: return 4608;
			3'd2, 3'd6: return -4608;
			3'd3:       return 5632;
			3'd4:       return -5632;
			default:    return 0;
		endcase
	endfunction

	function automatic longint home_y(input logic [2:0] l);
		case (l)
			3'd1, 3'd2: return -3840;
			3'd5, 3'd6: return 3840;
			default:    return 0;
		endcase
	endfunction

	function automatic void heading(input logic [2:0] d, input logic [2:0] l,
			output longint hx, output longint hy);
		longint side;
		// turning moves front and rear legs sideways in opposite senses, middle legs not at all
		side = (l == 3'd1 || l == 3'd2) ? 1 : ((l == 3'd5 || l == 3'd6) ? -1 : 0);
		hx = 0;
		hy = 0;
		case (d)
			DIR_FWD:        hy = -1;
			DIR_BACK:       hy = 1;
			DIR_LEFT:       hx = 1;
			DIR_RIGHT:      hx = -1;
			DIR_TURN_LEFT:  hx = side;
			DIR_TURN_RIGHT: hx = -side;
			default: ;
		endcase
	endfunction

	function automatic logic signed [15:0] clip16(input longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return 16'(v);
	endfunction

	function automatic foot_point_t predict_point();
		longint unsigned nn, ii, den, num, frac, mag, st, lh, arc;
		longint hx, hy, m, z;
		foot_point_t p;
		nn = 64'(n_q);
		ii = 64'(idx_q);
		st = 64'(stride);
		lh = 64'(lift);
		// smoothstep as an exact fraction num/den, rounded half up on the magnitude
		den = nn * nn * nn;
		num = ii * ii * (3 * nn - 2 * ii);
		frac = swinging ? num : den - num;
		mag = (st * frac + den / 2) / den;
		m = mag;
		heading(dir_q, leg_q, hx, hy);
		if (!swinging) begin
			hx = -hx;
			hy = -hy;
		end
		z = HOME_Z;
		if (swinging) begin
			arc = (4 * lh * ii * (nn - ii) + nn * nn / 2) / (nn * nn);
			z = z + longint'(arc);
		end
		p.x = clip16(home_x(leg_q) + hx * m);
		p.y = clip16(home_y(leg_q) + hy * m);
		p.z = clip16(z);
		p.index = idx_q;
		p.fin = (idx_q == n_q);
		return p;
	endfunction

	task automatic check_field(input string what, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		foot_point_t want;
		logic [9:0] n;
		if (!arst_n) begin
			stride = 15'd1536;
			lift = 15'd1024;
			swing_n = 10'd120;
			stance_n = 10'd60;
			walking = 1'b0;
			swinging = 1'b0;
			leg_q = 3'd1;
			dir_q = 3'd0;
			idx_q = '0;
			n_q = 10'd1;
			points_due.delete();
			fail_count = 0;
			points_owed = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_STEP_LENGTH:   stride = cfg_data;
					REG_LIFT_HEIGHT:   lift = cfg_data;
					REG_SWING_POINTS:  swing_n = cfg_data[9:0];
					REG_STANCE_POINTS: stance_n = cfg_data[9:0];
					default: ;
				endcase
			end
			// a point can never come from the word taken at the same edge, so check first
			if (out_valid && !out_stall) begin
				if (points_due.size() == 0) begin
					$display("%0t: point %0d (%0d,%0d,%0d) with none expected", $time,
						point_number, pos_x, pos_y, pos_z);
					fail_count++;
				end else begin
					want = points_due.pop_front();
					check_field("pos_x", longint'(want.x), longint'(pos_x));
					check_field("pos_y", longint'(want.y), longint'(pos_y));
					check_field("pos_z", longint'(want.z), longint'(pos_z));
					check_field("point_number", longint'(want.index), longint'(point_number));
					check_field("last", longint'(want.fin), longint'(last));
				end
			end
			if (in_valid && !in_stall) begin
				case (kind)
					KIND_START_SWING, KIND_START_STANCE: begin
						// legs outside one to six leave the phase untouched
						if (leg >= 3'd1 && leg <= 3'd6) begin
							n = (kind == KIND_START_SWING) ? swing_n : stance_n;
							if (n == 0)
								n = 10'd1;
							walking = 1'b1;
							swinging = (kind == KIND_START_SWING);
							leg_q = leg;
							dir_q = direction;
							idx_q = '0;
							n_q = n;
						end
					end
					KIND_TICK: begin
						if (walking) begin
							want = predict_point();
							points_due.push_back(want);
							if (want.fin)
								walking = 1'b0;
							else
								idx_q = idx_q + 10'd1;
						end
					end
					default: ;
				endcase
			end
			points_owed = points_due.size();
		end
	end

endmodule

// ===== dv/gait_foot_trajectory_generator_core_test.sv =====
// Stimulus and verdict for gait_foot_trajectory_generator_core: directed words, then random
// walks over several register settings. Checking lives in gftg_point_checker; uses gftg_pkg.
`timescale 1ns / 100ps

module gait_foot_trajectory_generator_core_test;
	import gftg_pkg::*;

	localparam int         DRAIN_CYCLES  = 250;
	localparam int         QUIET_LIMIT   = 5000;
	localparam logic [1:0] KIND_RESERVED = 2'd3;
	localparam logic [2:0] DIR_NONE_LO   = 3'd6;
	localparam logic [2:0] DIR_NONE_HI   = 3'd7;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [RegBits-1:0] cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         kind = '0;
	logic [2:0]         leg = '0;
	logic [2:0]         direction = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] pos_z;
	logic [9:0]         point_number;
	logic               last;

	int          fail_count;
	int          points_owed;
	int          burst_left = 0;
	int          quiet_cycles = 0;
	int          stall_span = 0;
	int          hold_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	logic [9:0]  swing_n = 10'd120;
	logic [9:0]  stance_n = 10'd60;

	always #6 clk = ~clk;

	gait_foot_trajectory_generator_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.leg          (leg),
		.direction    (direction),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.point_number (point_number),
		.last         (last)
	);

	gftg_point_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.leg          (leg),
		.direction    (direction),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.point_number (point_number),
		.last         (last),
		.fail_count   (fail_count),
		.points_owed  (points_owed)
	);

	// receiver: switches between stall patterns, long holds let a finished point wait
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_span = $urandom_range(100, 3000);
		end else
			stall_span--;
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= 1'($urandom_range(0, 1));
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				if (hold_left == 0) begin
					hold_left = $urandom_range(1, 300);
					out_stall <= !out_stall;
				end else
					hold_left--;
			end
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("gait_foot_trajectory_generator_core regression: fail");
			$finish;
		end
	end

	// entered and left at a falling edge; valid stays up between words of a burst
	task automatic send_word(input logic [1:0] k, input logic [2:0] l, input logic [2:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
			burst_left = $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= k;
		leg <= l;
		direction <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// tick words carry random leg and direction bits, which the block ignores
	task automatic walk(input logic [1:0] k, input logic [2:0] l, input logic [2:0] d,
			input int ticks);
		send_word(k, l, d);
		repeat (ticks)
			send_word(KIND_TICK, 3'($urandom), 3'($urandom));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (points_owed != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	// upper data bits of the count registers are junk the block must drop
	task automatic load_regs(input logic [14:0] s, input logic [14:0] h,
			input logic [9:0] sw, input logic [9:0] st);
		cfg_we <= 1'b1;
		cfg_index <= REG_STEP_LENGTH;
		cfg_data <= s;
		@(negedge clk);
		cfg_index <= REG_LIFT_HEIGHT;
		cfg_data <= h;
		@(negedge clk);
		cfg_index <= REG_SWING_POINTS;
		cfg_data <= {5'($urandom), sw};
		@(negedge clk);
		cfg_index <= REG_STANCE_POINTS;
		cfg_data <= {5'($urandom), st};
		@(negedge clk);
		cfg_we <= 1'b0;
		swing_n = sw;
		stance_n = st;
	endtask

	function automatic int phase_points(input logic [1:0] k);
		int n;
		n = (k == KIND_START_SWING) ? int'(swing_n) : int'(stance_n);
		return (n == 0) ? 1 : n;
	endfunction

	task automatic random_phase(input int budget);
		int done, n, ticks, pick;
		logic [1:0] k;
		logic [2:0] d;
		done = 0;
		while (done < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				k = 2'($urandom_range(0, 1));
				n = phase_points(k);
				d = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
					: 3'($urandom_range(0, 5));
				if (n + 1 > 16)
					ticks = $urandom_range(1, 12);
				else if (pick < 15)
					ticks = $urandom_range(0, n);
				else
					ticks = n + 1 + (($urandom_range(0, 9) == 0) ? 1 : 0);
				walk(k, 3'($urandom_range(1, 6)), d, ticks);
				done += 1 + ticks;
			end else
				send_word(2'($urandom), 3'($urandom), 3'($urandom));
		end
	endtask

	initial begin
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle block: tick, reserved kind and out-of-range legs change nothing
		send_word(KIND_TICK, 3'd1, DIR_FWD);
		send_word(KIND_RESERVED, 3'd3, DIR_BACK);
		send_word(KIND_START_SWING, 3'd0, DIR_LEFT);
		send_word(KIND_START_STANCE, 3'd7, DIR_RIGHT);
		walk(KIND_START_SWING, 3'd2, DIR_LEFT, 3);
		settle();

		// phase length stays latched, step length is read live
		load_regs(15'd1536, 15'd1024, 10'd3, 10'd2);
		send_word(KIND_TICK, 3'd0, DIR_NONE_HI);
		walk(KIND_START_SWING, 3'd1, DIR_FWD, 4);
		send_word(KIND_TICK, 3'd4, DIR_BACK);
		walk(KIND_START_STANCE, 3'd6, DIR_TURN_RIGHT, 1);
		walk(KIND_START_SWING, 3'd3, DIR_NONE_HI, 4);
		walk(KIND_START_STANCE, 3'd4, DIR_BACK, 3);
		walk(KIND_START_SWING, 3'd5, DIR_NONE_LO, 1);
		settle();

		load_regs(15'h7fff, 15'h7fff, 10'd5, 10'd4);
		random_phase(60);
		settle();
		load_regs('0, '0, '0, '0);
		random_phase(30);
		settle();
		load_regs(15'd1, 15'd1, 10'd1, 10'd1);
		random_phase(30);
		settle();
		repeat (6) begin
			load_regs(15'($urandom), 15'($urandom), 10'($urandom_range(1, 12)),
				10'($urandom_range(1, 12)));
			random_phase(50);
			settle();
		end
		load_regs(15'($urandom), 15'h7fff, 10'h3ff, 10'h3ff);
		random_phase(25);
		settle();

		if (fail_count == 0)
			$display("gait_foot_trajectory_generator_core regression: pass");
		else
			$display("gait_foot_trajectory_generator_core regression: fail");
		$finish;
	end

endmodule
